[hdl/tlbpt_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlbpt_pkg
// Shared codes and the front-to-back command type of the page translator.
// ----------------------------------------------------------------------------
package tlbpt_pkg;

    localparam logic [1:0] FUNC_TRANSLATE = 2'd0;
    localparam logic [1:0] FUNC_WRITE     = 2'd1;
    localparam logic [1:0] FUNC_FLUSH     = 2'd2;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_INVALID  = 2'd1;
    localparam logic [1:0] ST_FAULT    = 2'd2;
    localparam logic [1:0] ST_DONE     = 2'd3;

    localparam logic CFG_PAGES = 1'b0;
    localparam logic CFG_TLB   = 1'b1;

    // classified command as the front hands it to the back
    typedef struct packed {
        logic [1:0]  kind;       // FUNC_* code, unknown codes become flush-less done
        logic        in_range;   // translate page below limit
        logic        pid_ok;     // process id below process count
        logic        page_ok;    // write page below max pages
        logic [15:0] page;       // page number (translate) or entry page (write)
        logic [5:0]  pid;
        logic [15:0] offset;
        logic [19:0] frame;      // write frame
        logic        evalid;
    } cmd_t;

endpackage

[hdl/tlb_page_translator.sv]
`timescale 1ns / 1ps
// translations: the page table read on acceptance, the TLB lookup and LRU
// update, then the result handoff; writes and flushes skip the lookup. A new
// item is taken only once the previous result has been handed off
// reset: asynchronous, active low; after reset the page table valid bits are
// cleared by a sweep over all PROCESSES*MAX_PAGES entries before items proceed
// ----------------------------------------------------------------------------
// tlb_page_translator
// Fully associative LRU TLB in front of per-process page tables.
// ----------------------------------------------------------------------------
module tlb_page_translator #(
    parameter int PAGE_BITS  = 12,
    parameter int MAX_PAGES  = 1024,
    parameter int TLB_DEPTH  = 16,
    parameter int PROCESSES  = 8,
    parameter int FRAME_BITS = 10
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // func[1:0], process_id[4:2], virtual_address[36:5], entry_page[46:37],
    // entry_frame[56:47], entry_valid[57], zero pad
    input  logic [63:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // status[1:0], tlb_hit[2], frame_number, page_offset, zero pad
    output logic [((2 + 1 + FRAME_BITS + PAGE_BITS + 7) / 8) * 8 - 1:0] m_axis_tdata,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [10:0] cfg_data
);
    localparam int OW = ((2 + 1 + FRAME_BITS + PAGE_BITS + 7) / 8) * 8;

    logic [10:0]           pages_reg;
    logic [4:0]            tlbn_reg;
    logic                  q_valid, q_ready;
    tlbpt_pkg::cmd_t       q_cmd;
    logic [1:0]            status;
    logic                  tlb_hit;
    logic [FRAME_BITS-1:0] frame_number;
    logic [PAGE_BITS-1:0]  page_offset;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pages_reg <= 11'd1024;
            tlbn_reg <= 5'd16;
        end
        else if (cfg_valid)
        begin
            if (cfg_index == tlbpt_pkg::CFG_PAGES)
                pages_reg <= cfg_data;
            else
                tlbn_reg <= cfg_data[4:0];
        end
    end

    tlbpt_front #(.PAGE_BITS(PAGE_BITS), .MAX_PAGES(MAX_PAGES), .PROCESSES(PROCESSES),
                  .FRAME_BITS(FRAME_BITS)) u_front (
        .clk(clk), .rst_n(rst_n),
        .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
        .func(s_axis_tdata[1:0]), .process_id(s_axis_tdata[4:2]),
        .virtual_address(s_axis_tdata[36:5]), .entry_page(s_axis_tdata[46:37]),
        .entry_frame(s_axis_tdata[56:47]), .entry_valid(s_axis_tdata[57]),
        .pages_in_use(pages_reg),
        .q_valid(q_valid), .q_ready(q_ready), .q_cmd(q_cmd)
    );

    tlbpt_back #(.MAX_PAGES(MAX_PAGES), .TLB_DEPTH(TLB_DEPTH), .PROCESSES(PROCESSES),
                 .FRAME_BITS(FRAME_BITS), .PAGE_BITS(PAGE_BITS)) u_back (
        .clk(clk), .rst_n(rst_n),
        .q_valid(q_valid), .q_ready(q_ready), .q_cmd(q_cmd),
        .tlb_entries_in_use(tlbn_reg),
        .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
        .status(status), .tlb_hit(tlb_hit),
        .frame_number(frame_number), .page_offset(page_offset)
    );

    assign m_axis_tdata = OW'({page_offset, frame_number, tlb_hit, status});
endmodule

[hdl/tlbpt_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlbpt_front
// Accepts input beats, classifies them and pushes them into a two-entry queue.
// ----------------------------------------------------------------------------
module tlbpt_front #(
    parameter int PAGE_BITS  = 12,
    parameter int MAX_PAGES  = 1024,
    parameter int PROCESSES  = 8,
    parameter int FRAME_BITS = 10
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [1:0]          func,
    input  logic [2:0]          process_id,
    input  logic [31:0]         virtual_address,
    input  logic [9:0]          entry_page,
    input  logic [9:0]          entry_frame,
    input  logic                entry_valid,
    input  logic [10:0]         pages_in_use,
    output logic                q_valid,
    input  logic                q_ready,
    output tlbpt_pkg::cmd_t     q_cmd
);
    tlbpt_pkg::cmd_t q_reg [2];
    logic            rd_reg, rd_next;
    logic            wr_reg, wr_next;
    logic [1:0]      cnt_reg, cnt_next;
    tlbpt_pkg::cmd_t cmd;
    logic [31:0]     page_full;
    logic [31:0]     limit;
    logic            push, pop;

    always_comb
    begin
        page_full = virtual_address >> PAGE_BITS;
        limit = (32'(pages_in_use) > 32'(MAX_PAGES)) ? 32'(MAX_PAGES) : 32'(pages_in_use);
        cmd = '0;
        cmd.kind = func;
        cmd.in_range = page_full < limit;
        cmd.pid_ok = 32'(process_id) < 32'(PROCESSES);
        cmd.page_ok = 32'(entry_page) < 32'(MAX_PAGES);
        cmd.pid = 6'(process_id);
        cmd.offset = 16'(virtual_address & ((32'd1 << PAGE_BITS) - 32'd1));
        cmd.frame = 20'(entry_frame & 10'((20'd1 << FRAME_BITS) - 20'd1));
        cmd.evalid = entry_valid;
        if (func == tlbpt_pkg::FUNC_TRANSLATE)
            cmd.page = 16'(page_full);
        else
            cmd.page = 16'(entry_page);
    end

    assign in_ready = cnt_reg != 2'd2;
    assign push = in_valid && in_ready;
    assign q_valid = cnt_reg != 2'd0;
    assign pop = q_valid && q_ready;
    assign q_cmd = q_reg[rd_reg];

    always_comb
    begin
        rd_next = pop ? !rd_reg : rd_reg;
        wr_next = push ? !wr_reg : wr_reg;
        cnt_next = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_reg <= 1'b0;
            wr_reg <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            rd_reg <= rd_next;
            wr_reg <= wr_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            q_reg[wr_reg] <= cmd;
    end
endmodule

[hdl/tlbpt_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlbpt_back
// Executes queued commands: TLB lookup with LRU ranks, page table access.
// ----------------------------------------------------------------------------
module tlbpt_back #(
    parameter int MAX_PAGES  = 1024,
    parameter int TLB_DEPTH  = 16,
    parameter int PROCESSES  = 8,
    parameter int FRAME_BITS = 10,
    parameter int PAGE_BITS  = 12
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  q_valid,
    output logic                  q_ready,
    input  tlbpt_pkg::cmd_t       q_cmd,
    input  logic [4:0]            tlb_entries_in_use,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [1:0]            status,
    output logic                  tlb_hit,
    output logic [FRAME_BITS-1:0] frame_number,
    output logic [PAGE_BITS-1:0]  page_offset
);
    localparam int PGW  = $clog2(MAX_PAGES);
    localparam int PIDW = (PROCESSES > 1) ? $clog2(PROCESSES) : 1;
    localparam int TW   = $clog2(PROCESSES * MAX_PAGES);
    localparam int TSZ  = PROCESSES * MAX_PAGES;
    localparam int SW   = $clog2(TLB_DEPTH);
    localparam int CW   = $clog2(TLB_DEPTH + 1);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_LOOK  = 2'd1;
    localparam logic [1:0] S_CLEAR = 2'd3;

    logic [1:0]  st_reg, st_next;
    tlbpt_pkg::cmd_t cur_reg;

    logic [PGW-1:0]        tag_reg  [TLB_DEPTH];
    logic [FRAME_BITS-1:0] tfr_reg  [TLB_DEPTH];
    logic [SW-1:0]         rank_reg [TLB_DEPTH];
    logic [CW-1:0]         fill_reg;

    logic [FRAME_BITS-1:0] tbl_frame [TSZ];
    logic                  tbl_valid [TSZ];
    logic [FRAME_BITS-1:0] rd_frame_reg;
    logic                  rd_valid_reg;
    logic [TW-1:0]         clr_reg;

    logic [1:0]            o_status_reg;
    logic                  o_hit_reg;
    logic [FRAME_BITS-1:0] o_frame_reg;
    logic [PAGE_BITS-1:0]  o_off_reg;
    logic                  o_valid_reg;

    logic                  hit;
    logic [SW-1:0]         hit_slot;
    logic [SW-1:0]         lru_slot;
    logic [CW-1:0]         cap;
    logic [TW-1:0]         addr;
    logic                  take;

    assign q_ready = (st_reg == S_IDLE) && !o_valid_reg;
    assign take = q_valid && q_ready;
    assign addr = TW'(q_cmd.pid[PIDW-1:0]) * TW'(MAX_PAGES) + TW'(q_cmd.page[PGW-1:0]);

    always_comb
    begin
        hit = 1'b0;
        hit_slot = '0;
        lru_slot = '0;
        for (int i = TLB_DEPTH - 1; i >= 0; i--)
        begin
            if (CW'(i) < fill_reg && tag_reg[i] == cur_reg.page[PGW-1:0])
            begin
                hit = 1'b1;
                hit_slot = SW'(i);
            end
            if (CW'(i) < fill_reg && CW'(rank_reg[i]) == fill_reg - CW'(1))
                lru_slot = SW'(i);
        end
        cap = (tlb_entries_in_use == 5'd0) ? CW'(1)
            : ((32'(tlb_entries_in_use) > 32'(TLB_DEPTH)) ? CW'(TLB_DEPTH)
            : CW'(tlb_entries_in_use));
    end

    always_comb
    begin
        st_next = st_reg;
        case (st_reg)
            S_CLEAR: if (clr_reg == TW'(TSZ - 1)) st_next = S_IDLE;
            S_IDLE:  if (take) st_next = (q_cmd.kind == tlbpt_pkg::FUNC_TRANSLATE
                                          && q_cmd.in_range) ? S_LOOK : S_IDLE;
            S_LOOK:  st_next = S_IDLE;
            default: st_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= S_CLEAR;
            clr_reg <= '0;
            fill_reg <= '0;
            o_valid_reg <= 1'b0;
        end
        else
        begin
            st_reg <= st_next;
            if (st_reg == S_CLEAR)
                clr_reg <= clr_reg + TW'(1);
            if (out_valid && out_ready)
                o_valid_reg <= 1'b0;
            if (take && q_cmd.kind == tlbpt_pkg::FUNC_FLUSH)
                fill_reg <= '0;
            if (take && (q_cmd.kind != tlbpt_pkg::FUNC_TRANSLATE || !q_cmd.in_range))
                o_valid_reg <= 1'b1;
            if (st_reg == S_LOOK)
            begin
                o_valid_reg <= 1'b1;
                if (!hit && cur_reg.pid_ok && rd_valid_reg && fill_reg < cap)
                    fill_reg <= fill_reg + CW'(1);
            end
        end
    end

    // page table memory, one port shared by clear sweep, reads and writes
    always_ff @(posedge clk)
    begin
        if (st_reg == S_CLEAR)
            tbl_valid[clr_reg] <= 1'b0;
        else if (take && q_cmd.kind == tlbpt_pkg::FUNC_WRITE && q_cmd.pid_ok && q_cmd.page_ok)
        begin
            tbl_valid[addr] <= q_cmd.evalid;
            if (q_cmd.evalid)
                tbl_frame[addr] <= q_cmd.frame[FRAME_BITS-1:0];
        end
        else if (take)
        begin
            rd_valid_reg <= tbl_valid[addr];
            rd_frame_reg <= tbl_frame[addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            cur_reg <= q_cmd;
            o_hit_reg <= 1'b0;
            o_frame_reg <= '0;
            o_off_reg <= (q_cmd.kind == tlbpt_pkg::FUNC_TRANSLATE)
                       ? q_cmd.offset[PAGE_BITS-1:0] : '0;
            if (q_cmd.kind == tlbpt_pkg::FUNC_TRANSLATE)
                o_status_reg <= tlbpt_pkg::ST_INVALID;
            else
                o_status_reg <= tlbpt_pkg::ST_DONE;
        end
        if (st_reg == S_LOOK)
        begin
            if (hit)
            begin
                o_status_reg <= tlbpt_pkg::ST_OK;
                o_hit_reg <= 1'b1;
                o_frame_reg <= tfr_reg[hit_slot];
                for (int i = 0; i < TLB_DEPTH; i++)
                    if (CW'(i) < fill_reg && rank_reg[i] < rank_reg[hit_slot])
                        rank_reg[i] <= rank_reg[i] + SW'(1);
                rank_reg[hit_slot] <= '0;
            end
            else if (cur_reg.pid_ok && rd_valid_reg)
            begin
                o_status_reg <= tlbpt_pkg::ST_OK;
                o_frame_reg <= rd_frame_reg;
                if (fill_reg < cap)
                begin
                    // new slot at end, every live entry ages
                    for (int i = 0; i < TLB_DEPTH; i++)
                        if (CW'(i) < fill_reg)
                            rank_reg[i] <= rank_reg[i] + SW'(1);
                    tag_reg[fill_reg[SW-1:0]] <= cur_reg.page[PGW-1:0];
                    tfr_reg[fill_reg[SW-1:0]] <= rd_frame_reg;
                    rank_reg[fill_reg[SW-1:0]] <= '0;
                end
                else
                begin
                    for (int i = 0; i < TLB_DEPTH; i++)
                        if (CW'(i) < fill_reg && rank_reg[i] < rank_reg[lru_slot])
                            rank_reg[i] <= rank_reg[i] + SW'(1);
                    tag_reg[lru_slot] <= cur_reg.page[PGW-1:0];
                    tfr_reg[lru_slot] <= rd_frame_reg;
                    rank_reg[lru_slot] <= '0;
                end
            end
            else
                o_status_reg <= tlbpt_pkg::ST_FAULT;
        end
    end

    assign out_valid = o_valid_reg;
    assign status = o_status_reg;
    assign tlb_hit = o_hit_reg;
    assign frame_number = o_frame_reg;
    assign page_offset = o_off_reg;
endmodule

[hdl/tlbpt_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlbpt_checker
// Port-level checks on the translator result stream.
// ----------------------------------------------------------------------------
module tlbpt_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [31:0] m_axis_tdata
);
    // a hit is only reported with a successful translation
    a_hit_ok: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[2] |-> m_axis_tdata[1:0] == tlbpt_pkg::ST_OK)
        else $error("hit without translation");

    // failed or non-translate results carry no frame
    a_frame_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[1:0] != tlbpt_pkg::ST_OK |-> m_axis_tdata[12:3] == 10'd0)
        else $error("frame on failed result");

    // write or flush results have no offset
    a_done_off: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[1:0] == tlbpt_pkg::ST_DONE |-> m_axis_tdata[24:13] == 12'd0)
        else $error("offset on done result");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result dropped while stalled");
endmodule

bind tlb_page_translator tlbpt_checker u_checker (
    .clk(clk), .rst_n(rst_n), .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata)
);
